@@ rtl/sfcs_pkg.sv @@
// Shared types, constants and result builders for the SPI flash command sequencer.
// No dependencies; every other file of the block imports this package.
package sfcs_pkg;

    // Geometry and limits of the flash transactions.
    localparam int SECTOR_BYTES = 4096;
    localparam int MAX_LEN      = 4096;
    localparam int MAXR         = 8;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 24;
    localparam int LEN_W   = 13;
    localparam int LIMIT_W = 20;
    localparam int FAULT_W = 16;
    localparam int PADDR_W = 3;

    // Derived widths.
    localparam int SEC_W = $clog2(SECTOR_BYTES);
    localparam int SUM_W = ((SEC_W > LEN_W) ? SEC_W : LEN_W) + 1;
    localparam int CNT_W = $clog2(MAXR + 1);
    localparam int IDX_W = $clog2(MAXR);

    localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = LIMIT_W'(1000000);

    // Register map.
    localparam logic [PADDR_W-1:0] REG_POLL_LIMIT = 3'd0;

    // Host command codes.
    localparam logic [2:0] CMD_ERASE   = 3'd0;
    localparam logic [2:0] CMD_PROGRAM = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_POWER   = 3'd3;
    localparam logic [2:0] CMD_PDATA   = 3'd4;
    localparam logic [2:0] CMD_REPLY   = 3'd5;

    // Flash opcodes and filler bytes.
    localparam logic [7:0] OP_PAGE_PROG   = 8'h02;
    localparam logic [7:0] OP_READ_STATUS = 8'h05;
    localparam logic [7:0] OP_WRITE_EN    = 8'h06;
    localparam logic [7:0] OP_FAST_READ   = 8'h0B;
    localparam logic [7:0] OP_ERASE_4K    = 8'h20;
    localparam logic [7:0] OP_ERASE_32K   = 8'h52;
    localparam logic [7:0] OP_ERASE_64K   = 8'hD8;
    localparam logic [7:0] OP_ERASE_CHIP  = 8'h60;
    localparam logic [7:0] OP_DEEP_DOWN   = 8'hB9;
    localparam logic [7:0] OP_RELEASE     = 8'hAB;
    localparam logic [7:0] BYTE_POLL      = 8'hFF;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    localparam logic [1:0] MODE_CHIP = 2'd3;
    localparam logic [1:0] MODE_DOWN = 2'd0;

    typedef enum logic [1:0] {
        KIND_SPI  = 2'd0,
        KIND_NEED = 2'd1,
        KIND_READ = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    // One result item, without the fields that the queue adds.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] spi_byte;
        logic       end_frame;
        logic       want_reply;
        logic [7:0] host_data;
        logic       timed_out;
    } res_t;

    // All results of one transaction, handed from the core to the result queue.
    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [FAULT_W-1:0] faults;
        res_t [MAXR-1:0]    ent;
    } batch_t;

    function automatic res_t spi_res(logic [7:0] b, logic ef, logic wr);
        res_t r;
        r            = '0;
        r.kind       = KIND_SPI;
        r.spi_byte   = b;
        r.end_frame  = ef;
        r.want_reply = wr;
        return r;
    endfunction

    function automatic res_t need_res();
        res_t r;
        r      = '0;
        r.kind = KIND_NEED;
        return r;
    endfunction

    function automatic res_t read_res(logic [7:0] d);
        res_t r;
        r           = '0;
        r.kind      = KIND_READ;
        r.host_data = d;
        return r;
    endfunction

    function automatic res_t done_res(logic to);
        res_t r;
        r           = '0;
        r.kind      = KIND_DONE;
        r.timed_out = to;
        return r;
    endfunction

    function automatic logic [7:0] erase_opcode(logic [1:0] m);
        logic [7:0] op;
        unique case (m)
            2'd0:    op = OP_ERASE_4K;
            2'd1:    op = OP_ERASE_32K;
            2'd2:    op = OP_ERASE_64K;
            default: op = OP_ERASE_CHIP;
        endcase
        return op;
    endfunction

endpackage

@@ rtl/sfcs_core.sv @@
// Sequencer core: flash transaction state and the single-pass step that turns one
// input transaction into a batch of results. Depends on sfcs_pkg.
module sfcs_core
    import sfcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [2:0]         cmd,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [1:0]         mode,
    input  logic [LEN_W-1:0]   length,
    input  logic [7:0]         data,
    input  logic [LIMIT_W-1:0] poll_limit,
    output batch_t             batch
);

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_EBUSY = 9'b000000010,
        PH_EWEL  = 9'b000000100,
        PH_WBUSY = 9'b000001000,
        PH_WWEL  = 9'b000010000,
        PH_DATA  = 9'b000100000,
        PH_FINAL = 9'b001000000,
        PH_PBUSY = 9'b010000000,
        PH_RDATA = 9'b100000000
    } phase_t;

    phase_t             phase_reg,       phase_next;
    logic [1:0]         operation_reg,   operation_next;
    logic [1:0]         saved_mode_reg,  saved_mode_next;
    logic [ADDR_W-1:0]  cur_addr_reg,    cur_addr_next;
    logic [LEN_W-1:0]   bytes_left_reg,  bytes_left_next;
    logic [LEN_W-1:0]   second_part_reg, second_part_next;
    logic [LIMIT_W-1:0] polls_left_reg,  polls_left_next;
    logic [FAULT_W-1:0] faults_reg,      faults_next;

    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] polls_dec;
    logic [LEN_W-1:0]   len_c;
    logic [SUM_W-1:0]   span_end;
    logic [LEN_W-1:0]   split_len;
    logic               span_splits;
    logic [LEN_W-1:0]   bytes_dec;
    res_t [MAXR-1:0]    res;
    logic [CNT_W-1:0]   n;
    logic               to;

    // Operand preparation shared by several branches of the step.
    assign lim         = (poll_limit == '0) ? LIMIT_W'(1) : poll_limit;
    assign polls_dec   = (polls_left_reg != '0) ? polls_left_reg - LIMIT_W'(1) : '0;
    assign len_c       = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;
    assign span_end    = SUM_W'(addr[SEC_W-1:0]) + SUM_W'(len_c);
    assign span_splits = span_end > SUM_W'(SECTOR_BYTES);
    assign split_len   = LEN_W'(span_end[SEC_W-1:0]);
    assign bytes_dec   = bytes_left_reg - LEN_W'(1);

    // One step of the sequencer: next state and the ordered list of results.
    always_comb
    begin
        phase_next       = phase_reg;
        operation_next   = operation_reg;
        saved_mode_next  = saved_mode_reg;
        cur_addr_next    = cur_addr_reg;
        bytes_left_next  = bytes_left_reg;
        second_part_next = second_part_reg;
        polls_left_next  = polls_left_reg;
        faults_next      = faults_reg;
        res              = '0;
        n                = '0;
        to               = 1'b0;

        if (go && cmd <= CMD_POWER && phase_reg == PH_IDLE) begin
            operation_next = cmd[1:0];
            cur_addr_next  = addr;
            if (cmd == CMD_PROGRAM) begin
                if (span_splits) begin
                    second_part_next = split_len;
                    bytes_left_next  = len_c - split_len;
                end else begin
                    second_part_next = '0;
                    bytes_left_next  = len_c;
                end
                phase_next = (addr[SEC_W-1:0] == '0) ? PH_EBUSY : PH_WBUSY;
            end else if (cmd == CMD_ERASE) begin
                saved_mode_next = mode;
                phase_next      = PH_EBUSY;
            end else begin
                if (cmd == CMD_POWER) begin
                    saved_mode_next = mode;
                end
                bytes_left_next = len_c;
                phase_next      = PH_PBUSY;
            end
            polls_left_next = lim;
            res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0); n = n + CNT_W'(1);
            res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);      n = n + CNT_W'(1);
        end else if (go && cmd == CMD_PDATA && phase_reg == PH_DATA) begin
            // Program data byte goes straight out; the last one starts the final wait.
            res[n[IDX_W-1:0]] = spi_res(data, bytes_left_reg == LEN_W'(1), 1'b0);
            n = n + CNT_W'(1);
            bytes_left_next = bytes_dec;
            cur_addr_next   = cur_addr_reg + ADDR_W'(1);
            if (bytes_dec != '0) begin
                res[n[IDX_W-1:0]] = need_res(); n = n + CNT_W'(1);
            end else begin
                polls_left_next = lim - LIMIT_W'(1);
                phase_next      = PH_FINAL;
                res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0); n = n + CNT_W'(1);
                res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);      n = n + CNT_W'(1);
            end
        end else if (go && cmd == CMD_REPLY) begin
            unique case (phase_reg)
                PH_EBUSY, PH_WBUSY:
                begin
                    if (data[0] && polls_left_reg != '0) begin
                        polls_left_next = polls_dec;
                    end else begin
                        res[n[IDX_W-1:0]] = spi_res(OP_WRITE_EN, 1'b1, 1'b0);
                        n = n + CNT_W'(1);
                        phase_next = (phase_reg == PH_EBUSY) ? PH_EWEL : PH_WWEL;
                    end
                    res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0); n = n + CNT_W'(1);
                    res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);      n = n + CNT_W'(1);
                end
                PH_EWEL, PH_WWEL:
                begin
                    polls_left_next = polls_dec;
                    if ((data[0] || !data[1]) && polls_dec != '0) begin
                        res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                        n = n + CNT_W'(1);
                    end else if (phase_reg == PH_EWEL && operation_reg == CMD_ERASE[1:0]) begin
                        // Erase command itself, then the transaction is over.
                        if (saved_mode_reg == MODE_CHIP) begin
                            res[n[IDX_W-1:0]] = spi_res(OP_ERASE_CHIP, 1'b1, 1'b0);
                            n = n + CNT_W'(1);
                        end else begin
                            res[n[IDX_W-1:0]] = spi_res(erase_opcode(saved_mode_reg), 1'b0, 1'b0);
                            n = n + CNT_W'(1);
                            res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[23:16], 1'b0, 1'b0);
                            n = n + CNT_W'(1);
                            res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[15:8], 1'b0, 1'b0);
                            n = n + CNT_W'(1);
                            res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[7:0], 1'b1, 1'b0);
                            n = n + CNT_W'(1);
                        end
                        res[n[IDX_W-1:0]] = done_res(1'b0); n = n + CNT_W'(1);
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_EWEL) begin
                        // Sector erase ahead of a program, then a fresh write enable.
                        res[n[IDX_W-1:0]] = spi_res(OP_ERASE_4K, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[23:16], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[15:8], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[7:0], 1'b1, 1'b0);
                        n = n + CNT_W'(1);
                        polls_left_next = lim;
                        phase_next      = PH_WBUSY;
                        res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                        n = n + CNT_W'(1);
                    end else begin
                        // Page program header.
                        res[n[IDX_W-1:0]] = spi_res(OP_PAGE_PROG, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[23:16], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[15:8], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[7:0],
                                                    bytes_left_reg == '0, 1'b0);
                        n = n + CNT_W'(1);
                        if (bytes_left_reg != '0) begin
                            res[n[IDX_W-1:0]] = need_res(); n = n + CNT_W'(1);
                            phase_next = PH_DATA;
                        end else begin
                            polls_left_next = lim - LIMIT_W'(1);
                            phase_next      = PH_FINAL;
                            res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                            n = n + CNT_W'(1);
                            res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                            n = n + CNT_W'(1);
                        end
                    end
                end
                PH_FINAL:
                begin
                    if (data[1:0] != 2'b00 && polls_left_reg != '0) begin
                        polls_left_next = polls_dec;
                        res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                        n = n + CNT_W'(1);
                    end else begin
                        if (data[1:0] != 2'b00) begin
                            to = 1'b1;
                            if (faults_reg != '1) begin
                                faults_next = faults_reg + FAULT_W'(1);
                            end
                        end
                        if (second_part_reg != '0) begin
                            // Second sector of a split program: erase it first.
                            bytes_left_next  = second_part_reg;
                            second_part_next = '0;
                            polls_left_next  = lim;
                            phase_next       = PH_EBUSY;
                            res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                            n = n + CNT_W'(1);
                            res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                            n = n + CNT_W'(1);
                        end else begin
                            res[n[IDX_W-1:0]] = done_res(to); n = n + CNT_W'(1);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_PBUSY:
                begin
                    if (data[0] && polls_left_reg != '0) begin
                        polls_left_next = polls_dec;
                        res[n[IDX_W-1:0]] = spi_res(OP_READ_STATUS, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(BYTE_POLL, 1'b1, 1'b1);
                        n = n + CNT_W'(1);
                    end else if (operation_reg == CMD_POWER[1:0]) begin
                        res[n[IDX_W-1:0]] = spi_res((saved_mode_reg == MODE_DOWN) ?
                                                    OP_DEEP_DOWN : OP_RELEASE, 1'b1, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = done_res(1'b0); n = n + CNT_W'(1);
                        phase_next = PH_IDLE;
                    end else begin
                        // Fast read header with one dummy byte.
                        res[n[IDX_W-1:0]] = spi_res(OP_FAST_READ, 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[23:16], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[15:8], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(cur_addr_reg[7:0], 1'b0, 1'b0);
                        n = n + CNT_W'(1);
                        res[n[IDX_W-1:0]] = spi_res(BYTE_ZERO, bytes_left_reg == '0, 1'b0);
                        n = n + CNT_W'(1);
                        if (bytes_left_reg != '0) begin
                            res[n[IDX_W-1:0]] = spi_res(BYTE_ZERO,
                                                        bytes_left_reg == LEN_W'(1), 1'b1);
                            n = n + CNT_W'(1);
                            phase_next = PH_RDATA;
                        end else begin
                            res[n[IDX_W-1:0]] = done_res(1'b0); n = n + CNT_W'(1);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_RDATA:
                begin
                    res[n[IDX_W-1:0]] = read_res(data); n = n + CNT_W'(1);
                    bytes_left_next = bytes_dec;
                    if (bytes_dec != '0) begin
                        res[n[IDX_W-1:0]] = spi_res(BYTE_ZERO, bytes_dec == LEN_W'(1), 1'b1);
                        n = n + CNT_W'(1);
                    end else begin
                        res[n[IDX_W-1:0]] = done_res(1'b0); n = n + CNT_W'(1);
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    // Idle or waiting for program data: a stray reply is dropped.
                end
            endcase
        end

        batch.cnt    = n;
        batch.faults = faults_next;
        batch.ent    = res;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            operation_reg   <= '0;
            saved_mode_reg  <= '0;
            cur_addr_reg    <= '0;
            bytes_left_reg  <= '0;
            second_part_reg <= '0;
            polls_left_reg  <= '0;
            faults_reg      <= '0;
        end else begin
            phase_reg       <= phase_next;
            operation_reg   <= operation_next;
            saved_mode_reg  <= saved_mode_next;
            cur_addr_reg    <= cur_addr_next;
            bytes_left_reg  <= bytes_left_next;
            second_part_reg <= second_part_next;
            polls_left_reg  <= polls_left_next;
            faults_reg      <= faults_next;
        end
    end

endmodule

@@ rtl/sfcs_resq.sv @@
// Result queue: holds the batch of one transaction and hands the results out one per cycle
// while result_stall is low. Depends on sfcs_pkg.
module sfcs_resq
    import sfcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  batch_t             batch,
    input  logic               result_stall,
    output logic               result_valid,
    output res_t               head,
    output logic [FAULT_W-1:0] fault_count,
    output logic               last,
    output logic               free
);

    res_t [MAXR-1:0]    ent_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [FAULT_W-1:0] faults_reg;
    logic               pop;

    assign pop          = (cnt_reg != '0) && !result_stall;
    assign free         = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pop);
    assign result_valid = cnt_reg != '0;
    assign head         = ent_reg[0];
    assign fault_count  = faults_reg;
    assign last         = cnt_reg == CNT_W'(1);

    // Count of results still to be delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= batch.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Result entries shift towards the head as each one is taken.
    always_ff @(posedge clk)
    begin
        if (load) begin
            ent_reg    <= batch.ent;
            faults_reg <= batch.faults;
        end else if (pop) begin
            for (int i = 0; i < MAXR - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
    end

endmodule

@@ rtl/spi_flash_command_sequencer.sv @@
// Top level of the SPI flash command sequencer: configuration port, input register,
// sequencer core and result queue. Depends on sfcs_pkg, sfcs_core and sfcs_resq.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  item      | item_valid / item_stall    | cmd, addr, mode, length, data
//  result    | result_valid / result_stall| kind, spi_byte, end_frame, want_reply,
//            |                            | host_data, timed_out, fault_count, last
//  config    | APB psel/penable/pwrite    | poll_limit at byte address 0
//
// A transaction is registered on acceptance and processed once the result queue is
// empty or giving out its last result; its first result appears in the cycle after that.
// A transaction with k results holds the result queue until all k are taken (k is at
// most six), so that queue sets the rate at which transactions are processed.
// Reset is asynchronous and clears the core state, queue count and input flag; poll_limit resets to
// 1000000. A stalled result holds the queue, and a stalled queue stalls the input.
module spi_flash_command_sequencer
    import sfcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         cmd,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [1:0]         mode,
    input  logic [LEN_W-1:0]   length,
    input  logic [7:0]         data,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         kind,
    output logic [7:0]         spi_byte,
    output logic               end_frame,
    output logic               want_reply,
    output logic [7:0]         host_data,
    output logic               timed_out,
    output logic [FAULT_W-1:0] fault_count,
    output logic               last
);

    logic [LIMIT_W-1:0] poll_limit_reg;
    logic               full_reg;
    logic [2:0]         cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [1:0]         mode_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [7:0]         data_reg;
    logic               take;
    logic               accept;
    logic               q_free;
    batch_t             batch;
    res_t               head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_POLL_LIMIT) ? 32'(poll_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_POLL_LIMIT) begin
            poll_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Input register: refilled in the same cycle its transaction moves on.
    assign take       = full_reg && q_free;
    assign item_stall = full_reg && !q_free;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= accept || (full_reg && !take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg    <= cmd;
            addr_reg   <= addr;
            mode_reg   <= mode;
            length_reg <= length;
            data_reg   <= data;
        end
    end

    sfcs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (take),
        .cmd        (cmd_reg),
        .addr       (addr_reg),
        .mode       (mode_reg),
        .length     (length_reg),
        .data       (data_reg),
        .poll_limit (poll_limit_reg),
        .batch      (batch)
    );

    sfcs_resq u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take),
        .batch        (batch),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .head         (head),
        .fault_count  (fault_count),
        .last         (last),
        .free         (q_free)
    );

    assign kind       = head.kind;
    assign spi_byte   = head.spi_byte;
    assign end_frame  = head.end_frame;
    assign want_reply = head.want_reply;
    assign host_data  = head.host_data;
    assign timed_out  = head.timed_out;

    // A processed transaction with results shows its first result in the next cycle.
    a_batch_shows: assert property (@(posedge clk) disable iff (!rst_n)
        take && batch.cnt != '0 |=> result_valid)
        else $error("results of a processed transaction did not appear");

    // The fault count seen on consecutive results never goes down.
    a_faults_rise: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid) |-> fault_count >= $past(fault_count))
        else $error("fault count decreased");

    // A held transaction stays in the input register until the core takes it.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !take |=> full_reg && $stable(cmd_reg) && $stable(data_reg))
        else $error("held input transaction lost or changed");

endmodule
